// ----- rtl/core/hedu_pkg.sv -----
package hedu_pkg;

  localparam int unsigned SpanMax  = 10;
  localparam int unsigned WinDepth = SpanMax + 1;
  localparam int unsigned FillW    = $clog2(WinDepth + 1);
  localparam int unsigned IdxW     = $clog2(WinDepth);

  localparam logic [7:0] ChAmp  = 8'h26;
  localparam logic [7:0] ChSemi = 8'h3b;
  localparam logic [7:0] ChHash = 8'h23;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic decide;
    logic pop_emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic front_amp;
    logic scan_done;
    logic can_decide;
    logic more_out;
  } stat_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    to_lower = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

  // digit value, bit 4 set means not a digit
  function automatic logic [4:0] digit_val(input logic [7:0] c, input logic hex);
    logic [7:0] l;
    l = to_lower(c);
    if (c >= 8'h30 && c <= 8'h39) digit_val = {1'b0, c[3:0]};
    else if (hex && l >= 8'h61 && l <= 8'h66) digit_val = {1'b0, l[3:0] + 4'd9};
    else digit_val = 5'h10;
  endfunction

  // look up a name: chars packed low char first, 6 chars of 8 bits
  function automatic logic [1+16-1:0] name_lookup(input logic [47:0] s, input logic [2:0] len);
    logic [16:0] r;
    r = '0;
    case (len)
      3'd2: begin
        if (s[15:0] == 16'h746c) r = {1'b1, 8'h3c, 8'h00};
        if (s[15:0] == 16'h7467) r = {1'b1, 8'h3e, 8'h00};
      end
      3'd3: if (s[23:0] == 24'h706d61) r = {1'b1, 8'h26, 8'h00};
      3'd4: begin
        if (s[31:0] == 32'h7073626e) r = {1'b1, 8'hc2, 8'ha0};
        if (s[31:0] == 32'h746f7571) r = {1'b1, 8'h22, 8'h00};
        if (s[31:0] == 32'h736f7061) r = {1'b1, 8'h27, 8'h00};
      end
      3'd5: begin
        if (s[39:0] == 40'h637269636f) r = {1'b1, 8'hc3, 8'hb4};
        if (s[39:0] == 40'h6372696365) r = {1'b1, 8'hc3, 8'haa};
        if (s[39:0] == 40'h6372696369) r = {1'b1, 8'hc3, 8'hae};
      end
      3'd6: begin
        if (s == 48'h657475636165) r = {1'b1, 8'hc3, 8'ha9};
        if (s == 48'h657661726765) r = {1'b1, 8'hc3, 8'ha8};
        if (s == 48'h657661726761) r = {1'b1, 8'hc3, 8'ha0};
        if (s == 48'h6c6964656363) r = {1'b1, 8'hc3, 8'ha7};
        if (s == 48'h657661726775) r = {1'b1, 8'hc3, 8'hb9};
        if (s == 48'h657475636161) r = {1'b1, 8'hc3, 8'ha1};
      end
      default: r = '0;
    endcase
    name_lookup = r;
  endfunction

endpackage

// ----- rtl/core/html_entity_decoder_utf8_top.sv -----
// HTML character reference decoder, byte stream in, UTF-8 byte stream out.
// Input channel: in_byte_i/in_last_i with in_valid_i/in_ready_o. in_last_i
// marks the final byte of a text and flushes all pending bytes.
// Output channel: out_byte_o/out_last_o with out_valid_o/out_ready_i.
// out_last_o flags the last byte produced by one input transfer.
// A window of up to eleven bytes holds text after an '&' until a ';' shows
// up, the span runs out, or the text ends.
// Sequence: an input transfer is taken in the idle state, the window front is
// checked in the scan state, and the first output byte is then offered from
// the emit state. Each window front gets one check and each result byte one emit.
// An '&' front is rescanned one window byte per cycle on every input, then,
// for a numeric reference, runs its digits up to a non-digit, gets a check
// and a decode step, and its bytes go out one per cycle while out_ready_i is high.
// The single sequencer is the limit: the block takes no input while it is
// emitting. A stalled receiver simply holds the sequencer in its emit state.
// Reset empties the window and returns to waiting for input.
module html_entity_decoder_utf8_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  hedu_pkg::cmd_t  cmd;
  hedu_pkg::stat_t stat;

  hedu_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .out_ready_i,
    .stat_i(stat), .in_ready_o, .out_valid_o, .cmd_o(cmd)
  );

  hedu_dp u_dp (
    .clk_i, .rst_ni, .in_byte_i, .in_last_i,
    .cmd_i(cmd), .stat_o(stat), .out_byte_o, .out_last_o
  );

endmodule

// ----- rtl/core/hedu_ctrl.sv -----
module hedu_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             out_ready_i,
  input  hedu_pkg::stat_t  stat_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output hedu_pkg::cmd_t   cmd_o
);

  hedu_pkg::state_e state_q, state_d;

  // advance state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= hedu_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      hedu_pkg::ST_IDLE: if (in_valid_i) state_d = hedu_pkg::ST_SCAN;
      hedu_pkg::ST_SCAN: begin
        if (stat_i.empty) state_d = hedu_pkg::ST_IDLE;
        else if (!stat_i.front_amp) state_d = hedu_pkg::ST_EMIT;
        else if (stat_i.scan_done) begin
          if (stat_i.can_decide) state_d = hedu_pkg::ST_DONE;
          else state_d = hedu_pkg::ST_IDLE;
        end
      end
      hedu_pkg::ST_DONE: state_d = hedu_pkg::ST_EMIT;
      hedu_pkg::ST_EMIT:
        if (out_ready_i && !stat_i.more_out) state_d = hedu_pkg::ST_SCAN;
      default: state_d = hedu_pkg::ST_IDLE;
    endcase
  end

  // drive commands
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      hedu_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      hedu_pkg::ST_SCAN: cmd_o.scan = stat_i.front_amp && !stat_i.scan_done;
      hedu_pkg::ST_DONE: cmd_o.decide = 1'b1;
      hedu_pkg::ST_EMIT: begin
        out_valid_o    = 1'b1;
        cmd_o.pop_emit = out_ready_i;
      end
      default: ;
    endcase
  end

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("both channels open");
  a_scan_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hedu_pkg::ST_EMIT && out_ready_i && !stat_i.more_out)
      |=> state_q == hedu_pkg::ST_SCAN) else $error("emit exit");
  a_decide_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.decide |=> out_valid_o) else $error("decide not emitted");

endmodule

// ----- rtl/core/hedu_dp.sv -----
module hedu_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      in_byte_i,
  input  logic            in_last_i,
  input  hedu_pkg::cmd_t  cmd_i,
  output hedu_pkg::stat_t stat_o,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o
);

  logic [7:0] win_q [hedu_pkg::WinDepth];
  logic [hedu_pkg::FillW-1:0] fill_q;
  logic final_q;
  // scan pointer, found semicolon position
  logic [hedu_pkg::FillW-1:0] k_q, semi_q;
  logic found_q;
  // numeric accumulator (low 32 bits kept), digit loop over k
  logic [31:0] acc_q;
  logic num_stop_q;
  // result bytes
  logic [7:0] ob_q [4];
  logic [2:0] on_q, oi_q;
  logic [hedu_pkg::FillW-1:0] pop_q;

  logic hex, is_num;
  logic [hedu_pkg::FillW-1:0] dstart;
  logic [4:0] dv;
  logic [47:0] nm;
  logic [16:0] hit;
  logic [hedu_pkg::FillW-1:0] ilen;
  logic [7:0] cur;
  logic lit;
  logic last_pending;
  logic [hedu_pkg::FillW-1:0] rem;
  logic [hedu_pkg::FillW-1:0] pn;

  assign hex    = (win_q[2] == 8'h78) || (win_q[2] == 8'h58);
  assign is_num = win_q[1] == hedu_pkg::ChHash;
  assign dstart = hex ? hedu_pkg::FillW'(3) : hedu_pkg::FillW'(2);
  assign cur    = win_q[k_q[hedu_pkg::IdxW-1:0]];
  assign dv     = hedu_pkg::digit_val(cur, hex);
  assign ilen   = semi_q - hedu_pkg::FillW'(1);

  always_comb begin
    for (int j = 0; j < 6; j++) nm[j*8 +: 8] = hedu_pkg::to_lower(win_q[j+1]);
    hit = (ilen <= hedu_pkg::FillW'(6)) ? hedu_pkg::name_lookup(nm, ilen[2:0]) : '0;
  end

  // status
  always_comb begin
    stat_o.empty      = fill_q == '0;
    stat_o.front_amp  = win_q[0] == hedu_pkg::ChAmp;
    stat_o.scan_done  = found_q ? (num_stop_q || !is_num || k_q >= semi_q)
                                : (k_q >= fill_q);
    stat_o.can_decide = found_q || final_q ||
                        (fill_q - hedu_pkg::FillW'(1) >= hedu_pkg::FillW'(hedu_pkg::SpanMax));
    stat_o.more_out   = (oi_q + 3'd1 < on_q);
  end

  // output byte: literal front or decoded bytes
  assign lit        = (win_q[0] != hedu_pkg::ChAmp) && on_q == 3'd0;
  assign out_byte_o = lit ? win_q[0] : ob_q[oi_q[1:0]];
  assign out_last_o = !stat_o.more_out && last_pending;

  // last result of a step: window after pop cannot produce more
  assign pn  = lit ? hedu_pkg::FillW'(1) : pop_q;
  assign rem = fill_q - pn;
  always_comb begin
    // a pending '&' with no ';' in reach stops the step unless the text ends
    last_pending = 1'b1;
    if (rem != '0) begin
      if (final_q || win_q[pn[hedu_pkg::IdxW-1:0]] != hedu_pkg::ChAmp) last_pending = 1'b0;
      else begin
        for (int j = 1; j < hedu_pkg::WinDepth; j++)
          if (hedu_pkg::FillW'(j) > pn && hedu_pkg::FillW'(j) < fill_q &&
              win_q[j] == hedu_pkg::ChSemi)
            last_pending = 1'b0;
        if (rem - hedu_pkg::FillW'(1) >= hedu_pkg::FillW'(hedu_pkg::SpanMax))
          last_pending = 1'b0;
      end
    end
  end

  logic [31:0] cp;
  assign cp = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      final_q <= 1'b0;
      k_q <= '0; semi_q <= '0; found_q <= 1'b0;
      acc_q <= '0; num_stop_q <= 1'b0;
      on_q <= '0; oi_q <= '0; pop_q <= '0;
    end else begin
      if (cmd_i.load) begin
        if (fill_q < hedu_pkg::FillW'(hedu_pkg::WinDepth)) begin
          win_q[fill_q[hedu_pkg::IdxW-1:0]] <= in_byte_i;
          fill_q <= fill_q + hedu_pkg::FillW'(1);
        end
        final_q <= in_last_i;
        k_q <= hedu_pkg::FillW'(1); found_q <= 1'b0; acc_q <= '0; num_stop_q <= 1'b0;
        on_q <= '0; oi_q <= '0;
      end
      // scan: first find ';', then run digits
      if (cmd_i.scan) begin
        if (!found_q) begin
          if (cur == hedu_pkg::ChSemi) begin
            found_q <= 1'b1; semi_q <= k_q; k_q <= dstart;
          end else k_q <= k_q + hedu_pkg::FillW'(1);
        end else if (dv[4]) num_stop_q <= 1'b1;
        else begin
          acc_q <= (hex ? {acc_q[27:0], 4'd0} : (acc_q << 3) + (acc_q << 1)) + 32'(dv[3:0]);
          k_q <= k_q + hedu_pkg::FillW'(1);
        end
      end
      // decide result bytes
      if (cmd_i.decide) begin
        oi_q <= '0;
        if (found_q && semi_q <= hedu_pkg::FillW'(hedu_pkg::SpanMax) && is_num) begin
          pop_q <= semi_q + hedu_pkg::FillW'(1);
          if (cp <= 32'h7f) begin on_q <= 3'd1; ob_q[0] <= cp[7:0]; end
          else if (cp <= 32'h7ff) begin
            on_q <= 3'd2; ob_q[0] <= 8'hc0 | 8'(cp >> 6); ob_q[1] <= 8'h80 | {2'b0, cp[5:0]};
          end else if (cp <= 32'hffff) begin
            on_q <= 3'd3; ob_q[0] <= 8'he0 | 8'(cp >> 12);
            ob_q[1] <= 8'h80 | {2'b0, cp[11:6]}; ob_q[2] <= 8'h80 | {2'b0, cp[5:0]};
          end else begin
            on_q <= 3'd4; ob_q[0] <= 8'hf0 | 8'(cp >> 18);
            ob_q[1] <= 8'h80 | {2'b0, cp[17:12]}; ob_q[2] <= 8'h80 | {2'b0, cp[11:6]};
            ob_q[3] <= 8'h80 | {2'b0, cp[5:0]};
          end
        end else if (found_q && semi_q <= hedu_pkg::FillW'(hedu_pkg::SpanMax) && hit[16]) begin
          pop_q <= semi_q + hedu_pkg::FillW'(1);
          ob_q[0] <= hit[15:8]; ob_q[1] <= hit[7:0];
          on_q <= (hit[7:0] != 8'h00) ? 3'd2 : 3'd1;
        end else begin
          pop_q <= hedu_pkg::FillW'(1); on_q <= 3'd1; ob_q[0] <= hedu_pkg::ChAmp;
        end
      end
      // transfer one byte; pop window after last one
      if (cmd_i.pop_emit) begin
        if (stat_o.more_out) oi_q <= oi_q + 3'd1;
        else begin
          for (int j = 0; j < hedu_pkg::WinDepth; j++)
            if (j + int'(pn) < hedu_pkg::WinDepth) win_q[j] <= win_q[j + int'(pn)];
          fill_q <= (pn >= fill_q) ? '0 : fill_q - pn;
          on_q <= '0; oi_q <= '0; k_q <= hedu_pkg::FillW'(1); found_q <= 1'b0;
          acc_q <= '0; num_stop_q <= 1'b0;
          if (pn >= fill_q) final_q <= 1'b0;
        end
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= hedu_pkg::FillW'(hedu_pkg::WinDepth)) else $error("fill overflow");
  a_on_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    on_q <= 3'd4) else $error("result count overflow");
  a_oi_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (on_q != 3'd0) |-> (oi_q < on_q)) else $error("byte index past count");

endmodule
